FILE: design/dsg_pkg.sv
`timescale 1ns / 1ps

package dsg_pkg;

  localparam int MAX_RADIUS = 31;
  localparam int RAD_W      = 5;
  localparam int ROWS       = 2 * MAX_RADIUS + 1;
  localparam int ROW_W      = 6;
  // decision variable, two's complement, comfortably wider than its swing
  localparam int P_W        = 9;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_MARK_A,
    ST_MARK_B,
    ST_MARK_C,
    ST_MARK_D,
    ST_DRAIN,
    ST_PRIME,
    ST_EMIT
  } dsg_state_t;

  typedef enum logic [2:0] {
    MK_NONE,
    MK_FIRST,
    MK_A,
    MK_B,
    MK_C,
    MK_D
  } dsg_mark_t;

  typedef struct packed {
    logic      init;
    logic      step;
    dsg_mark_t mark;
    logic      prime;
    logic      emit;
  } dsg_cmd_t;

  typedef struct packed {
    logic x_lt_y;
    logic row_last;
    logic out_free;
  } dsg_status_t;

endpackage

FILE: design/dsg_ram.sv
`timescale 1ns / 1ps

module dsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

FILE: design/dsg_ctrl.sv
`timescale 1ns / 1ps

module dsg_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dsg_pkg::dsg_status_t status,
  output dsg_pkg::dsg_cmd_t    cmd
);
  import dsg_pkg::*;

  dsg_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mark  = MK_NONE;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.init  = 1'b1;
          state_nxt = ST_FIRST;
        end
      end
      ST_FIRST: begin
        cmd.mark = MK_FIRST;
        if (status.x_lt_y) begin
          cmd.step  = 1'b1;
          state_nxt = ST_MARK_A;
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_MARK_A: begin
        cmd.mark  = MK_A;
        state_nxt = ST_MARK_B;
      end
      ST_MARK_B: begin
        cmd.mark = MK_B;
        // walk ends when x catches y; otherwise the octant rows follow
        if (status.x_lt_y) begin
          state_nxt = ST_MARK_C;
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_MARK_C: begin
        cmd.mark  = MK_C;
        state_nxt = ST_MARK_D;
      end
      ST_MARK_D: begin
        cmd.mark  = MK_D;
        cmd.step  = 1'b1;
        state_nxt = ST_MARK_A;
      end
      ST_DRAIN: begin
        state_nxt = ST_PRIME;
      end
      ST_PRIME: begin
        cmd.prime = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = status.out_free;
        if (status.out_free && status.row_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/dsg_datapath.sv
`timescale 1ns / 1ps

module dsg_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [dsg_pkg::RAD_W-1:0]    in_radius,
  input  dsg_pkg::dsg_cmd_t            cmd,
  output dsg_pkg::dsg_status_t         status,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [dsg_pkg::ROW_W-1:0]    out_row_index,
  output logic [dsg_pkg::ROW_W-1:0]    out_span_offset,
  output logic [dsg_pkg::ROW_W-1:0]    out_span_amount,
  output logic                         out_last_row
);
  import dsg_pkg::*;

  logic [RAD_W-1:0] r_r, x_r, y_r, x_nxt, y_nxt;
  logic [P_W-1:0]   p_r, p_nxt, p_init, dxy;
  logic [ROW_W-1:0] r6, x6, y6, len;
  logic [ROW_W-1:0] row_cnt_r;
  logic [ROWS-1:0]  valid_r, valid_nxt;

  logic             mk_v;
  logic [ROW_W-1:0] mk_row, mk_col;
  logic             mk1_v_r;
  logic [ROW_W-1:0] mk1_row_r, mk1_col_r;
  logic             wb_v_r;
  logic [ROW_W-1:0] wb_row_r, wb_col_r;
  logic [ROW_W-1:0] cur_col, rd_addr, rdata;
  logic             old_v, wr_en;

  logic             out_valid_r;
  logic [ROW_W-1:0] out_row_r, out_off_r, out_amt_r;
  logic             out_last_r;
  logic [ROW_W-1:0] emit_off, emit_amt;

  assign r6  = {1'b0, r_r};
  assign x6  = {1'b0, x_r};
  assign y6  = {1'b0, y_r};
  assign len = {r_r, 1'b1};

  // starting decision (5 - 4r) / 4 truncated toward zero
  always_comb begin
    case (in_radius)
      RAD_W'(0): p_init = P_W'(1);
      RAD_W'(1): p_init = '0;
      default:   p_init = P_W'(2) - P_W'(in_radius);
    endcase
  end

  // one midpoint step
  always_comb begin
    x_nxt = x_r + 1'b1;
    y_nxt = p_r[P_W-1] ? y_r : y_r - 1'b1;
    dxy   = P_W'(x_nxt) - P_W'(y_nxt);
    if (p_r[P_W-1]) begin
      p_nxt = p_r + {3'b000, x_nxt, 1'b1};
    end else begin
      p_nxt = p_r + {dxy[P_W-2:0], 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      r_r <= in_radius;
      x_r <= '0;
      y_r <= in_radius;
      p_r <= p_init;
    end else if (cmd.step) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      p_r <= p_nxt;
    end
  end

  // mark request: row and candidate start column
  always_comb begin
    mk_v = (cmd.mark != MK_NONE);
    case (cmd.mark)
      MK_FIRST: begin
        mk_row = r6;
        mk_col = '0;
      end
      MK_A: begin
        mk_row = r6 - y6;
        mk_col = r6 - x6;
      end
      MK_B: begin
        mk_row = r6 + y6;
        mk_col = r6 - x6;
      end
      MK_C: begin
        mk_row = r6 - x6;
        mk_col = r6 - y6;
      end
      MK_D: begin
        mk_row = r6 + x6;
        mk_col = r6 - y6;
      end
      default: begin
        mk_row = row_cnt_r;
        mk_col = '0;
      end
    endcase
  end

  always_comb begin
    if (mk_v) begin
      rd_addr = mk_row;
    end else if (cmd.prime) begin
      rd_addr = '0;
    end else if (cmd.emit && !status.row_last) begin
      rd_addr = row_cnt_r + 1'b1;
    end else begin
      rd_addr = row_cnt_r;
    end
  end

  // second mark stage: keep the least column, bypass the write of last cycle
  assign cur_col = (wb_v_r && (wb_row_r == mk1_row_r)) ? wb_col_r : rdata;
  assign old_v   = valid_r[mk1_row_r];
  assign wr_en   = mk1_v_r && (!old_v || (mk1_col_r < cur_col));

  always_comb begin
    valid_nxt = valid_r;
    if (wr_en) begin
      valid_nxt[mk1_row_r] = 1'b1;
    end
    if (cmd.init) begin
      valid_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      mk1_v_r <= 1'b0;
      wb_v_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      mk1_v_r <= mk_v;
      wb_v_r  <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    mk1_row_r <= mk_row;
    mk1_col_r <= mk_col;
    wb_row_r  <= mk1_row_r;
    wb_col_r  <= mk1_col_r;
  end

  dsg_ram #(
    .WIDTH(ROW_W),
    .DEPTH(ROWS)
  ) u_row_start (
    .clk  (clk),
    .we   (wr_en),
    .waddr(mk1_row_r),
    .wdata(mk1_col_r),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.prime) begin
      row_cnt_r <= '0;
    end else if (cmd.emit && !status.row_last) begin
      row_cnt_r <= row_cnt_r + 1'b1;
    end
  end

  assign emit_off = valid_r[row_cnt_r] ? rdata : '0;
  assign emit_amt = valid_r[row_cnt_r] ? (len - {emit_off[ROW_W-2:0], 1'b0}) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_row_r  <= row_cnt_r;
      out_off_r  <= emit_off;
      out_amt_r  <= emit_amt;
      out_last_r <= status.row_last;
    end
  end

  assign status.x_lt_y   = (x_r < y_r);
  assign status.row_last = (row_cnt_r == {r_r, 1'b0});
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_row_index   = out_row_r;
  assign out_span_offset = out_off_r;
  assign out_span_amount = out_amt_r;
  assign out_last_row    = out_last_r;

  a_clear_on_init: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.init |=> (valid_r == '0))
    else $error("row marks not cleared at item start");

  a_center_row: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && (row_cnt_r == r6)) |-> (valid_r[row_cnt_r] && (rdata == '0)))
    else $error("center row read misaligned or not full width");

  a_walk_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!mk1_v_r && !wb_v_r))
    else $error("span emitted while a mark is still in flight");

  a_step_cond: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (x_r < y_r))
    else $error("circle step taken after walk end");

endmodule

FILE: design/disc_span_generator.sv
`timescale 1ns / 1ps

// filled disc span generator
// in channel: one word carries a radius (0..31); out channel: one word per
// mask row, top row first, giving row index, first filled column, filled
// column count and a last-row flag. 2r+1 words follow each radius word;
// rows that the circle never touches come out with offset 0 and amount 0.
// the midpoint walk comes first, then one row word per cycle while the
// receiver takes them; the walk is set by one read-compare-write of the
// row-start RAM per marked row (four marks per step), the drain by its
// single read port
// in_ready is high only between items; the next radius word is taken once
// the last row word sits in the output register, even if not yet taken
// receiver stall: the output register holds its word and the row walk pauses
// reset (rst_n low, synchronous): back to idle, output empty, row marks
// cleared; the row-start RAM needs no clearing since its word for a row is
// used only once that row's mark bit is set

module disc_span_generator (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [dsg_pkg::RAD_W-1:0] in_radius,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [dsg_pkg::ROW_W-1:0] out_row_index,
  output logic [dsg_pkg::ROW_W-1:0] out_span_offset,
  output logic [dsg_pkg::ROW_W-1:0] out_span_amount,
  output logic                      out_last_row
);
  import dsg_pkg::*;

  // commands from the sequencer, status back from the datapath
  dsg_cmd_t    cmd;
  dsg_status_t status;

  dsg_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  // walk registers, row-start RAM with mark bits, output register
  dsg_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_radius      (in_radius),
    .cmd            (cmd),
    .status         (status),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_row_index  (out_row_index),
    .out_span_offset(out_span_offset),
    .out_span_amount(out_span_amount),
    .out_last_row   (out_last_row)
  );

endmodule
